>>> rtl/clock_buffer_pool_replacement_core_defines.svh
// ---------------------------------------------------------------------------
// Clock buffer pool assertion macros
// Shared property forms for the checkers of the buffer pool core.
// ---------------------------------------------------------------------------
`ifndef CLOCK_BUFFER_POOL_REPLACEMENT_CORE_DEFINES_SVH
`define CLOCK_BUFFER_POOL_REPLACEMENT_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CLKBP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("clkbp assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CLKBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("clkbp assertion failed");

`endif

>>> rtl/clkbp_pkg.sv
// ---------------------------------------------------------------------------
// Clock buffer pool package
// Default sizes, port widths and the command word sent to the frame cells.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package clkbp_pkg;

    localparam int FRAMES_DEF    = 8;
    localparam int PAGE_BITS_DEF = 16;
    localparam int PIN_BITS_DEF  = 8;

    localparam int ID_W  = 16;
    localparam int IDX_W = 3;

    typedef struct packed {
        logic hit_upd;
        logic step;
    } t_cell_cmd;

endpackage

>>> rtl/clkbp_cell.sv
// ---------------------------------------------------------------------------
// Clock buffer pool frame cell
// Holds one frame and its share of the clock hand token.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module clkbp_cell #(
    parameter int PAGE_BITS  = clkbp_pkg::PAGE_BITS_DEF,
    parameter int PIN_BITS   = clkbp_pkg::PIN_BITS_DEF,
    parameter bit RESET_HAND = 1'b0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  clkbp_pkg::t_cell_cmd i_cmd,
    input  logic [PAGE_BITS-1:0] i_page,
    input  logic                 i_hand_left,
    output logic                 o_hand,
    output logic                 o_match,
    output logic                 o_pinned,
    output logic                 o_cand,
    output logic                 o_ev_valid,
    output logic [PAGE_BITS-1:0] o_ev_page
);

    logic [PAGE_BITS-1:0] r_page, n_page;
    logic                 r_valid, n_valid;
    logic                 r_ref, n_ref;
    logic [PIN_BITS-1:0]  r_pins, n_pins;
    logic                 r_hand, n_hand;

    assign o_hand     = r_hand;
    assign o_match    = r_valid && (r_page == i_page);
    assign o_pinned   = (r_pins != '0);
    assign o_cand     = i_hand_left && !o_pinned && !r_ref;
    assign o_ev_valid = o_cand && r_valid;
    assign o_ev_page  = o_ev_valid ? r_page : '0;

    always_comb begin
        n_page  = r_page;
        n_valid = r_valid;
        n_ref   = r_ref;
        n_pins  = r_pins;
        n_hand  = r_hand;
        if (i_cmd.hit_upd && o_match) begin
            if (r_pins != {PIN_BITS{1'b1}}) begin
                n_pins = r_pins + PIN_BITS'(1);
            end
            n_ref = 1'b1;
        end
        if (i_cmd.step) begin
            n_hand = i_hand_left;
            if (o_cand) begin
                n_page  = i_page;
                n_valid = 1'b1;
                n_ref   = 1'b1;
                n_pins  = PIN_BITS'(1);
            end else if (i_hand_left) begin
                n_ref = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_ref   <= 1'b0;
            r_pins  <= '0;
            r_hand  <= RESET_HAND;
        end else begin
            r_valid <= n_valid;
            r_ref   <= n_ref;
            r_pins  <= n_pins;
            r_hand  <= n_hand;
        end
    end

    always_ff @(posedge i_clk) begin
        r_page <= n_page;
    end

endmodule

>>> rtl/clkbp_ctrl.sv
// ---------------------------------------------------------------------------
// Clock buffer pool controller
// Sequences lookup and sweep, and holds the result item register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module clkbp_ctrl #(
    parameter int FRAMES    = clkbp_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = clkbp_pkg::PAGE_BITS_DEF,
    localparam int HAND_W   = $clog2(FRAMES)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [PAGE_BITS-1:0]                i_page,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [HAND_W-1:0]                   o_idx,
    output logic                                o_hit,
    output logic                                o_full,
    output logic                                o_ev_valid,
    output logic [PAGE_BITS-1:0]                o_ev_page,
    output clkbp_pkg::t_cell_cmd                o_cmd,
    output logic [PAGE_BITS-1:0]                o_page,
    input  logic [FRAMES-1:0]                   i_match,
    input  logic [FRAMES-1:0]                   i_pinned,
    input  logic [FRAMES-1:0]                   i_cand,
    input  logic [FRAMES-1:0]                   i_ev_valid,
    input  logic [FRAMES-1:0][PAGE_BITS-1:0]    i_ev_page
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_LOOK  = 2'd1;
    localparam logic [1:0] S_SWEEP = 2'd2;

    logic [1:0]           r_state, n_state;
    logic [PAGE_BITS-1:0] r_page, n_page;
    logic                 r_o_valid, n_o_valid;
    logic [HAND_W-1:0]    r_idx, n_idx;
    logic                 r_hit, n_hit;
    logic                 r_full, n_full;
    logic                 r_evv, n_evv;
    logic [PAGE_BITS-1:0] r_evp, n_evp;

    logic                 any_match;
    logic                 all_pinned;
    logic                 stop;
    logic                 can_out;
    logic [HAND_W-1:0]    match_idx;
    logic [HAND_W-1:0]    cand_idx;
    logic [PAGE_BITS-1:0] ev_page;

    assign any_match  = |i_match;
    assign all_pinned = &i_pinned;
    assign stop       = |i_cand;
    assign can_out    = !r_o_valid || i_ready;

    always_comb begin
        match_idx = '0;
        cand_idx  = '0;
        ev_page   = '0;
        for (int i = 0; i < FRAMES; i++) begin
            if (i_match[i]) begin
                match_idx = match_idx | HAND_W'(i);
            end
            if (i_cand[i]) begin
                cand_idx = cand_idx | HAND_W'(i);
            end
            ev_page = ev_page | i_ev_page[i];
        end
    end

    always_comb begin
        n_state   = r_state;
        n_page    = r_page;
        n_o_valid = r_o_valid;
        n_idx     = r_idx;
        n_hit     = r_hit;
        n_full    = r_full;
        n_evv     = r_evv;
        n_evp     = r_evp;
        o_cmd     = '0;
        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_page  = i_page;
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (!any_match && !all_pinned) begin
                    n_state = S_SWEEP;
                end else if (can_out) begin
                    o_cmd.hit_upd = any_match;
                    n_o_valid     = 1'b1;
                    n_idx         = any_match ? match_idx : '0;
                    n_hit         = any_match;
                    n_full        = !any_match;
                    n_evv         = 1'b0;
                    n_evp         = '0;
                    n_state       = S_IDLE;
                end
            end
            S_SWEEP: begin
                if (can_out) begin
                    o_cmd.step = 1'b1;
                    if (stop) begin
                        n_o_valid = 1'b1;
                        n_idx     = cand_idx;
                        n_hit     = 1'b0;
                        n_full    = 1'b0;
                        n_evv     = |i_ev_valid;
                        n_evp     = ev_page;
                        n_state   = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_page <= n_page;
        r_idx  <= n_idx;
        r_hit  <= n_hit;
        r_full <= n_full;
        r_evv  <= n_evv;
        r_evp  <= n_evp;
    end

    assign o_ready    = (r_state == S_IDLE);
    assign o_valid    = r_o_valid;
    assign o_idx      = r_idx;
    assign o_hit      = r_hit;
    assign o_full     = r_full;
    assign o_ev_valid = r_evv;
    assign o_ev_page  = r_evp;
    assign o_page     = r_page;

endmodule

>>> rtl/clock_buffer_pool_replacement_core.sv
// ---------------------------------------------------------------------------
// Clock buffer pool replacement core
// Second-chance page replacement over a row of frame cells.
// ---------------------------------------------------------------------------
//   channel   direction   handshake           payload
//   request   in          i_valid / o_ready   i_page_id
//   result    out         o_valid / i_ready   o_frame_index, o_hit, o_full_res,
//                                             o_evicted_valid, o_evicted_page
//
// After acceptance, a hit or a full pool loads the result register from the lookup state.
// On a miss, the sweep state moves the clock hand token through the cell row,
// one frame per cycle while the result register is free.
// The controller is ready for the next request once the result register loads.
// Reset clears all frames at once; no clearing pass is needed.
// A stalled result holds the sweep until the result register frees up.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module clock_buffer_pool_replacement_core #(
    parameter int FRAMES    = clkbp_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = clkbp_pkg::PAGE_BITS_DEF,
    parameter int PIN_BITS  = clkbp_pkg::PIN_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [clkbp_pkg::ID_W-1:0]  i_page_id,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [clkbp_pkg::IDX_W-1:0] o_frame_index,
    output logic                        o_hit,
    output logic                        o_full_res,
    output logic                        o_evicted_valid,
    output logic [clkbp_pkg::ID_W-1:0]  o_evicted_page
);

    localparam int HAND_W = $clog2(FRAMES);
    localparam int ID_W   = clkbp_pkg::ID_W;
    localparam int IDX_W  = clkbp_pkg::IDX_W;

    clkbp_pkg::t_cell_cmd            w_cmd;
    logic [PAGE_BITS-1:0]            w_page_in;
    logic [PAGE_BITS-1:0]            w_page;
    logic [HAND_W-1:0]               w_idx;
    logic [PAGE_BITS-1:0]            w_ev_page_out;
    logic [FRAMES-1:0]               w_hand;
    logic [FRAMES-1:0]               w_match;
    logic [FRAMES-1:0]               w_pinned;
    logic [FRAMES-1:0]               w_cand;
    logic [FRAMES-1:0]               w_ev_valid;
    logic [FRAMES-1:0][PAGE_BITS-1:0] w_ev_page;

    if (PAGE_BITS <= ID_W) begin : g_page_narrow
        assign w_page_in = i_page_id[PAGE_BITS-1:0];
    end else begin : g_page_wide
        assign w_page_in = {{(PAGE_BITS-ID_W){1'b0}}, i_page_id};
    end

    if (PAGE_BITS >= ID_W) begin : g_ev_wide
        assign o_evicted_page = w_ev_page_out[ID_W-1:0];
    end else begin : g_ev_narrow
        assign o_evicted_page = {{(ID_W-PAGE_BITS){1'b0}}, w_ev_page_out};
    end

    if (HAND_W >= IDX_W) begin : g_idx_wide
        assign o_frame_index = w_idx[IDX_W-1:0];
    end else begin : g_idx_narrow
        assign o_frame_index = {{(IDX_W-HAND_W){1'b0}}, w_idx};
    end

    clkbp_ctrl #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_page     (w_page_in),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_idx      (w_idx),
        .o_hit      (o_hit),
        .o_full     (o_full_res),
        .o_ev_valid (o_evicted_valid),
        .o_ev_page  (w_ev_page_out),
        .o_cmd      (w_cmd),
        .o_page     (w_page),
        .i_match    (w_match),
        .i_pinned   (w_pinned),
        .i_cand     (w_cand),
        .i_ev_valid (w_ev_valid),
        .i_ev_page  (w_ev_page)
    );

    for (genvar i = 0; i < FRAMES; i++) begin : g_cell
        clkbp_cell #(
            .PAGE_BITS  (PAGE_BITS),
            .PIN_BITS   (PIN_BITS),
            .RESET_HAND (i == FRAMES - 1)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (w_cmd),
            .i_page      (w_page),
            .i_hand_left (w_hand[(i + FRAMES - 1) % FRAMES]),
            .o_hand      (w_hand[i]),
            .o_match     (w_match[i]),
            .o_pinned    (w_pinned[i]),
            .o_cand      (w_cand[i]),
            .o_ev_valid  (w_ev_valid[i]),
            .o_ev_page   (w_ev_page[i])
        );
    end

endmodule

>>> rtl/clkbp_checker.sv
// ---------------------------------------------------------------------------
// Clock buffer pool checker
// Port-level checks on the result item and the request handshake.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "clock_buffer_pool_replacement_core_defines.svh"

module clkbp_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_ready,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic [clkbp_pkg::IDX_W-1:0] o_frame_index,
    input logic                        o_hit,
    input logic                        o_full_res,
    input logic                        o_evicted_valid,
    input logic [clkbp_pkg::ID_W-1:0]  o_evicted_page
);

    logic stalled;
    logic req_take;

    assign stalled  = o_valid && !i_ready;
    assign req_take = i_valid && o_ready;

    `CLKBP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, stalled, o_valid && $stable(o_frame_index) && $stable(o_hit) && $stable(o_full_res) && $stable(o_evicted_valid) && $stable(o_evicted_page))
    `CLKBP_ASSERT_SAME(a_full_clean, i_clk, i_rst_n, o_valid && o_full_res, o_frame_index == '0 && !o_hit && !o_evicted_valid)
    `CLKBP_ASSERT_SAME(a_hit_no_evict, i_clk, i_rst_n, o_valid && o_hit, !o_evicted_valid && !o_full_res && o_evicted_page == '0)
    `CLKBP_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, req_take, !o_ready)

endmodule

bind clock_buffer_pool_replacement_core clkbp_checker u_clkbp_checker (.*);

>>> test/tb_clock_buffer_pool_replacement_core.sv
// ---------------------------------------------------------------------------
// Clock buffer pool replacement core testbench
// Page requests fill the eight frames, then hit and overflow the pinned pool.
// Each result is compared with a second-chance replacement predictor held
// alongside the core. Both sides idle at random, apart from a steady
// stretch in the middle. The result side also holds off for a long
// stretch once, and the request side waits for a full drain once.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_clock_buffer_pool_replacement_core;

    localparam int FRAMES       = clkbp_pkg::FRAMES_DEF;
    localparam int PIN_BITS     = clkbp_pkg::PIN_BITS_DEF;
    localparam int ID_W         = clkbp_pkg::ID_W;
    localparam int IDX_W        = clkbp_pkg::IDX_W;
    localparam int PIN_MAX      = (1 << PIN_BITS) - 1;
    localparam int RANDOM_ITEMS = 600;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int SHOW_LIMIT   = 10;
    localparam int IDLE_PCT     = 26;
    localparam int HOLD_CYCLES  = 120;

    typedef struct packed {
        logic [IDX_W-1:0] frame;
        logic             hit;
        logic             full;
        logic             ev_valid;
        logic [ID_W-1:0]  ev_page;
    } t_lookup;

    typedef struct {
        logic [ID_W-1:0]  page;
        bit               known;
        logic [IDX_W-1:0] frame;
        logic             hit;
        logic             full;
    } t_request_row;

    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  i_valid   = 1'b0;
    logic [ID_W-1:0]       i_page_id = '0;
    logic                  i_ready   = 1'b0;
    logic                  o_ready;
    logic                  o_valid;
    logic [IDX_W-1:0]      o_frame_index;
    logic                  o_hit;
    logic                  o_full_res;
    logic                  o_evicted_valid;
    logic [ID_W-1:0]       o_evicted_page;

    logic [ID_W-1:0]       pool_page [FRAMES];
    bit                    pool_valid [FRAMES];
    bit                    pool_ref [FRAMES];
    int                    pool_pins [FRAMES];
    int                    pool_hand;

    t_lookup               pending_lookups [$];
    t_request_row          request_script [$];
    int                    errors;
    int                    requests_sent;
    int                    results_taken;

    clock_buffer_pool_replacement_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_page_id       (i_page_id),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_frame_index   (o_frame_index),
        .o_hit           (o_hit),
        .o_full_res      (o_full_res),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_page  (o_evicted_page)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic pool_lookup(input logic [ID_W-1:0] page, output t_lookup res);
        int  slot;
        bit  all_pinned;
        bit  stop;
        res  = '0;
        slot = -1;
        for (int i = FRAMES - 1; i >= 0; i--) begin
            if (pool_valid[i] && pool_page[i] == page) begin
                slot = i;
            end
        end
        if (slot >= 0) begin
            if (pool_pins[slot] < PIN_MAX) begin
                pool_pins[slot]++;
            end
            pool_ref[slot] = 1'b1;
            res.frame      = slot[IDX_W-1:0];
            res.hit        = 1'b1;
        end else begin
            all_pinned = 1'b1;
            for (int i = 0; i < FRAMES; i++) begin
                if (pool_pins[i] == 0) begin
                    all_pinned = 1'b0;
                end
            end
            if (all_pinned) begin
                res.full = 1'b1;
            end else begin
                stop = 1'b0;
                while (!stop) begin
                    pool_hand = (pool_hand + 1) % FRAMES;
                    if (pool_pins[pool_hand] == 0 && !pool_ref[pool_hand]) begin
                        stop = 1'b1;
                    end else begin
                        pool_ref[pool_hand] = 1'b0;
                    end
                end
                res.frame = pool_hand[IDX_W-1:0];
                if (pool_valid[pool_hand]) begin
                    res.ev_valid = 1'b1;
                    res.ev_page  = pool_page[pool_hand];
                end
                pool_page[pool_hand]  = page;
                pool_valid[pool_hand] = 1'b1;
                pool_ref[pool_hand]   = 1'b1;
                pool_pins[pool_hand]  = 1;
            end
        end
    endtask

    task automatic add_row(input logic [ID_W-1:0] page, input bit known,
                           input int frame, input bit hit, input bit full);
        t_request_row row;
        row.page  = page;
        row.known = known;
        row.frame = frame[IDX_W-1:0];
        row.hit   = hit;
        row.full  = full;
        request_script.push_back(row);
    endtask

    task automatic offer_request(input logic [ID_W-1:0] page);
        bit steady;
        steady = (requests_sent >= 300 && requests_sent < 420);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_page_id <= page;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        requests_sent++;
    endtask

    task automatic check_field(input string label, input logic [ID_W-1:0] want,
                               input logic [ID_W-1:0] got);
        if (want !== got) begin
            errors++;
            if (errors <= SHOW_LIMIT) begin
                $display("mismatch on result %0d, %s: expected %h, got %h",
                         results_taken, label, want, got);
            end
        end
    endtask

    initial begin
        t_lookup         res;
        logic [ID_W-1:0] page;
        int              pick;
        errors        = 0;
        requests_sent = 0;
        for (int i = 0; i < FRAMES; i++) begin
            pool_page[i]  = '0;
            pool_valid[i] = 1'b0;
            pool_ref[i]   = 1'b0;
            pool_pins[i]  = 0;
        end
        pool_hand = FRAMES - 1;

        // Page 0 must miss on an empty pool; the pool then fills in frame order.
        add_row(16'h0000, 1, 0, 0, 0);
        add_row(16'h0000, 1, 0, 1, 0);
        add_row(16'hFFFF, 1, 1, 0, 0);
        add_row(16'hFFFF, 1, 1, 1, 0);
        add_row(16'h5555, 1, 2, 0, 0);
        add_row(16'hAAAA, 1, 3, 0, 0);
        add_row(16'h0001, 1, 4, 0, 0);
        add_row(16'h8000, 1, 5, 0, 0);
        add_row(16'h7FFF, 1, 6, 0, 0);
        add_row(16'h1234, 1, 7, 0, 0);
        add_row(16'h4321, 1, 0, 0, 1);
        add_row(16'h1234, 1, 7, 1, 0);
        add_row(16'h0002, 1, 0, 0, 1);
        add_row(16'hFFFE, 1, 0, 0, 1);
        add_row(16'hAAAA, 1, 3, 1, 0);
        add_row(16'h5555, 1, 2, 1, 0);
        add_row(16'h8000, 1, 5, 1, 0);
        add_row(16'h7FFF, 1, 6, 1, 0);
        add_row(16'h0001, 1, 4, 1, 0);
        add_row(16'h0000, 0, 0, 0, 0);
        add_row(16'hEDCB, 0, 0, 0, 0);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (request_script[n]) begin
            offer_request(request_script[n].page);
            pool_lookup(request_script[n].page, res);
            if (request_script[n].known) begin
                res = '{request_script[n].frame, request_script[n].hit,
                        request_script[n].full, 1'b0, '0};
            end
            pending_lookups.push_back(res);
        end

        // Nearly half of the random requests hit frame 0 so that its pin count saturates.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 450) begin
                while (pending_lookups.size() != 0) begin
                    i_valid <= 1'b0;
                    @(posedge i_clk);
                end
            end
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                page = pool_page[0];
            end else if (pick < 75) begin
                page = pool_page[$urandom_range(0, FRAMES - 1)];
            end else begin
                page = ID_W'($urandom_range(0, (1 << ID_W) - 1));
            end
            offer_request(page);
            pool_lookup(page, res);
            pending_lookups.push_back(res);
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_lookups.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending_lookups.size() == 0) begin
            $display("tb_clock_buffer_pool_replacement_core: done, clean");
        end else begin
            $display("tb_clock_buffer_pool_replacement_core: done, errors");
        end
        $finish;
    end

    initial begin
        t_lookup want;
        int      hold_left;
        bit      hold_done;
        bit      steady;
        results_taken = 0;
        hold_left     = 0;
        hold_done     = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready) begin
                if (pending_lookups.size() == 0) begin
                    errors++;
                    if (errors <= SHOW_LIMIT) begin
                        $display("result %0d arrived with no request outstanding",
                                 results_taken);
                    end
                end else begin
                    want = pending_lookups.pop_front();
                    check_field("frame_index", ID_W'(want.frame), ID_W'(o_frame_index));
                    check_field("hit", ID_W'(want.hit), ID_W'(o_hit));
                    check_field("full_res", ID_W'(want.full), ID_W'(o_full_res));
                    check_field("evicted_valid", ID_W'(want.ev_valid),
                                ID_W'(o_evicted_valid));
                    check_field("evicted_page", want.ev_page, o_evicted_page);
                end
                results_taken++;
            end
            steady = (results_taken >= 300 && results_taken < 420);
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (!hold_done && results_taken >= 150) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                i_ready <= 1'b0;
            end else if (steady) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
            if (quiet >= STALL_LIMIT) begin
                $display("tb_clock_buffer_pool_replacement_core: done, errors");
                $finish;
            end
        end
    end

endmodule
